[src/ioe_pkg.sv]
// ----------------------------------------------------------------------------
// ioe_pkg
// Shared types, codes and constants of the integer operate executor:
// transfer payloads, decoded micro-op, write-port record and ALU op codes.
// ----------------------------------------------------------------------------
package ioe_pkg;

  // register file geometry
  localparam int unsigned NumRegs  = 31;
  localparam int unsigned DataW    = 64;
  localparam int unsigned RegIdxW  = 5;
  localparam logic [RegIdxW-1:0] ZeroReg = 5'd31;

  // func selector codes
  localparam logic [1:0] FuncExec  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncRead  = 2'd2;

  // major opcodes (bits 31:26)
  localparam logic [5:0] OpcArith = 6'h10;
  localparam logic [5:0] OpcLogic = 6'h11;
  localparam logic [5:0] OpcShift = 6'h12;
  localparam logic [5:0] OpcMul   = 6'h13;

  // function codes (bits 11:5), arithmetic group
  localparam logic [6:0] FnArAddq   = 7'h20;
  localparam logic [6:0] FnArSubq   = 7'h29;
  localparam logic [6:0] FnArAddl   = 7'h00;
  localparam logic [6:0] FnArSubl   = 7'h09;
  localparam logic [6:0] FnArS4Addq = 7'h22;
  localparam logic [6:0] FnArS8Addq = 7'h32;
  localparam logic [6:0] FnArS4Subq = 7'h2B;
  localparam logic [6:0] FnArS8Subq = 7'h3B;
  localparam logic [6:0] FnArCmpeq  = 7'h2D;
  localparam logic [6:0] FnArCmplt  = 7'h4D;
  localparam logic [6:0] FnArCmple  = 7'h6D;
  localparam logic [6:0] FnArCmpult = 7'h1D;
  localparam logic [6:0] FnArCmpule = 7'h3D;

  // logic group
  localparam logic [6:0] FnLgAnd   = 7'h00;
  localparam logic [6:0] FnLgBis   = 7'h20;
  localparam logic [6:0] FnLgXor   = 7'h40;
  localparam logic [6:0] FnLgBic   = 7'h08;
  localparam logic [6:0] FnLgOrnot = 7'h28;
  localparam logic [6:0] FnLgEqv   = 7'h48;

  // shift group
  localparam logic [6:0] FnShSll = 7'h39;
  localparam logic [6:0] FnShSrl = 7'h34;
  localparam logic [6:0] FnShSra = 7'h3C;

  // multiply group
  localparam logic [6:0] FnMulq = 7'h20;

  typedef enum logic [4:0] {
    AluAddq, AluSubq, AluAddl, AluSubl,
    AluS4Addq, AluS8Addq, AluS4Subq, AluS8Subq,
    AluCmpeq, AluCmplt, AluCmple, AluCmpult, AluCmpule,
    AluAnd, AluBis, AluXor, AluBic, AluOrnot, AluEqv,
    AluSll, AluSrl, AluSra, AluMulq,
    AluPassA, AluPassW, AluZero
  } alu_op_t;

  // input transfer payload
  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        instr_word;
    logic [RegIdxW-1:0] reg_index;
    logic [DataW-1:0]   write_value;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic               executed;
    logic [RegIdxW-1:0] dest_reg;
    logic [DataW-1:0]   result_value;
    logic               wrote;
  } out_item_t;

  // decoded item
  typedef struct packed {
    alu_op_t            op;
    logic [RegIdxW-1:0] ra;
    logic [RegIdxW-1:0] rb;
    logic [RegIdxW-1:0] dest;
    logic               use_lit;
    logic [7:0]         lit;
    logic               executed;
    logic               wen;
    logic [DataW-1:0]   wdata;
  } uop_t;

  // register write record (commit port and bypass sources)
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } wr_t;

endpackage

[src/integer_operate_executor_top.sv]
// ----------------------------------------------------------------------------
// integer_operate_executor_top
// Executes integer operate instructions against a 31 x 64 register file.
//
// Usage:
//   in_valid/in_ready/in_data carry one item per transfer: execute a word,
//   write a register, or read a register (func selector).
//   out_valid/out_ready/out_data return exactly one result per item, in order.
// Pipeline: issue (register file read), execute (bypass + ALU + multiply
// partial products), complete (product sum + write back), output register.
// The result reaches out_data through the execute, complete and output registers.
// Throughput: one item per cycle unless the output stalls or the MULQ interlock
// holds. An item whose operand is the destination of a MULQ directly ahead of it
// is held, as the product is only summed in the complete stage; all else is bypassed.
// Stall: while out_valid is high and out_ready low the whole pipeline holds
// and in_ready is low; otherwise an item is taken while a result waits.
// Reset: control state clears synchronously; register file entries read as
// zero through per-entry valid bits until written, so no clearing pass.
// ----------------------------------------------------------------------------
module integer_operate_executor_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ioe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ioe_pkg::out_item_t out_data
);

  // decode of one input item
  function automatic ioe_pkg::uop_t decode(input ioe_pkg::in_item_t it);
    ioe_pkg::uop_t u;
    logic [5:0]    opc;
    logic [6:0]    fn;
    logic          ok;
    u          = '0;
    u.op       = ioe_pkg::AluZero;
    u.ra       = ioe_pkg::ZeroReg;
    u.rb       = ioe_pkg::ZeroReg;
    u.wdata    = it.write_value;
    opc        = it.instr_word[31:26];
    fn         = it.instr_word[11:5];
    ok         = 1'b1;
    case (it.func)
      ioe_pkg::FuncExec: begin
        case (opc)
          ioe_pkg::OpcArith: begin
            case (fn)
              ioe_pkg::FnArAddq:   u.op = ioe_pkg::AluAddq;
              ioe_pkg::FnArSubq:   u.op = ioe_pkg::AluSubq;
              ioe_pkg::FnArAddl:   u.op = ioe_pkg::AluAddl;
              ioe_pkg::FnArSubl:   u.op = ioe_pkg::AluSubl;
              ioe_pkg::FnArS4Addq: u.op = ioe_pkg::AluS4Addq;
              ioe_pkg::FnArS8Addq: u.op = ioe_pkg::AluS8Addq;
              ioe_pkg::FnArS4Subq: u.op = ioe_pkg::AluS4Subq;
              ioe_pkg::FnArS8Subq: u.op = ioe_pkg::AluS8Subq;
              ioe_pkg::FnArCmpeq:  u.op = ioe_pkg::AluCmpeq;
              ioe_pkg::FnArCmplt:  u.op = ioe_pkg::AluCmplt;
              ioe_pkg::FnArCmple:  u.op = ioe_pkg::AluCmple;
              ioe_pkg::FnArCmpult: u.op = ioe_pkg::AluCmpult;
              ioe_pkg::FnArCmpule: u.op = ioe_pkg::AluCmpule;
              default:             ok   = 1'b0;
            endcase
          end
          ioe_pkg::OpcLogic: begin
            case (fn)
              ioe_pkg::FnLgAnd:   u.op = ioe_pkg::AluAnd;
              ioe_pkg::FnLgBis:   u.op = ioe_pkg::AluBis;
              ioe_pkg::FnLgXor:   u.op = ioe_pkg::AluXor;
              ioe_pkg::FnLgBic:   u.op = ioe_pkg::AluBic;
              ioe_pkg::FnLgOrnot: u.op = ioe_pkg::AluOrnot;
              ioe_pkg::FnLgEqv:   u.op = ioe_pkg::AluEqv;
              default:            ok   = 1'b0;
            endcase
          end
          ioe_pkg::OpcShift: begin
            case (fn)
              ioe_pkg::FnShSll: u.op = ioe_pkg::AluSll;
              ioe_pkg::FnShSrl: u.op = ioe_pkg::AluSrl;
              ioe_pkg::FnShSra: u.op = ioe_pkg::AluSra;
              default:          ok   = 1'b0;
            endcase
          end
          ioe_pkg::OpcMul: begin
            if (fn == ioe_pkg::FnMulq) begin
              u.op = ioe_pkg::AluMulq;
            end else begin
              ok = 1'b0;
            end
          end
          default: ok = 1'b0;
        endcase
        if (ok) begin
          u.executed = 1'b1;
          u.dest     = it.instr_word[4:0];
          u.wen      = (it.instr_word[4:0] != ioe_pkg::ZeroReg);
          u.ra       = it.instr_word[25:21];
          u.use_lit  = it.instr_word[12];
          u.lit      = it.instr_word[20:13];
          u.rb       = it.instr_word[12] ? ioe_pkg::ZeroReg : it.instr_word[20:16];
        end else begin
          u.op = ioe_pkg::AluZero;
        end
      end
      ioe_pkg::FuncWrite: begin
        u.op   = ioe_pkg::AluPassW;
        u.dest = it.reg_index;
        u.wen  = (it.reg_index != ioe_pkg::ZeroReg);
      end
      ioe_pkg::FuncRead: begin
        u.op   = ioe_pkg::AluPassA;
        u.ra   = it.reg_index;
        u.dest = it.reg_index;
      end
      default: u.op = ioe_pkg::AluZero;
    endcase
    return u;
  endfunction

  ioe_pkg::uop_t              in_uop;
  logic                       adv;
  logic                       stall;

  // execute stage
  logic                       s1_valid_r;
  ioe_pkg::uop_t              s1_uop_r;
  logic [ioe_pkg::DataW-1:0]  opnd_a;
  logic [ioe_pkg::DataW-1:0]  opnd_b;
  logic [ioe_pkg::DataW-1:0]  ex_b;
  logic [ioe_pkg::DataW-1:0]  alu_res;
  logic [63:0]                pp_ll;
  logic [31:0]                pp_lh;
  logic [31:0]                pp_hl;

  // complete stage
  logic                       s2_valid_r;
  logic                       s2_is_mul_r;
  logic                       s2_executed_r;
  logic                       s2_wen_r;
  logic [ioe_pkg::RegIdxW-1:0] s2_dest_r;
  logic [ioe_pkg::DataW-1:0]  s2_alu_r;
  logic [63:0]                s2_pp_ll_r;
  logic [31:0]                s2_pp_lh_r;
  logic [31:0]                s2_pp_hl_r;
  logic [ioe_pkg::DataW-1:0]  s2_result;
  ioe_pkg::wr_t               s2_fwd;
  ioe_pkg::wr_t               commit;

  // output register
  logic                       out_valid_r;
  ioe_pkg::out_item_t         out_data_r;

  // pipeline control
  always_comb begin
    in_uop   = decode(in_data);
    adv      = !out_valid_r || out_ready;
    stall    = s1_valid_r && s2_valid_r && s2_is_mul_r && s2_wen_r &&
               ((s1_uop_r.ra == s2_dest_r) || (s1_uop_r.rb == s2_dest_r));
    in_ready = adv && !stall;
  end

  // register file with bypass
  ioe_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_ready),
    .rd_addr_a (in_uop.ra),
    .rd_addr_b (in_uop.rb),
    .ex_idx_a  (s1_uop_r.ra),
    .ex_idx_b  (s1_uop_r.rb),
    .s2_fwd    (s2_fwd),
    .commit    (commit),
    .opnd_a    (opnd_a),
    .opnd_b    (opnd_b)
  );

  // operand two select
  assign ex_b = s1_uop_r.use_lit ? {56'd0, s1_uop_r.lit} : opnd_b;

  ioe_alu u_alu (
    .op    (s1_uop_r.op),
    .a     (opnd_a),
    .b     (ex_b),
    .wdata (s1_uop_r.wdata),
    .res   (alu_res),
    .pp_ll (pp_ll),
    .pp_lh (pp_lh),
    .pp_hl (pp_hl)
  );

  // product sum and write-back records
  always_comb begin
    s2_result   = s2_is_mul_r ?
                  (s2_pp_ll_r + {32'(s2_pp_lh_r + s2_pp_hl_r), 32'd0}) : s2_alu_r;
    s2_fwd.en   = s2_valid_r && s2_wen_r && !s2_is_mul_r;
    s2_fwd.idx  = s2_dest_r;
    s2_fwd.data = s2_alu_r;
    commit.en   = adv && s2_valid_r && s2_wen_r;
    commit.idx  = s2_dest_r;
    commit.data = s2_result;
  end

  // issue to execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_uop_r <= in_uop;
    end
  end

  // execute to complete, a bubble behind a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && !stall;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_is_mul_r   <= (s1_uop_r.op == ioe_pkg::AluMulq);
      s2_executed_r <= s1_uop_r.executed;
      s2_wen_r      <= s1_uop_r.wen;
      s2_dest_r     <= s1_uop_r.dest;
      s2_alu_r      <= alu_res;
      s2_pp_ll_r    <= pp_ll;
      s2_pp_lh_r    <= pp_lh;
      s2_pp_hl_r    <= pp_hl;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.executed     <= s2_executed_r;
      out_data_r.dest_reg     <= s2_dest_r;
      out_data_r.result_value <= s2_result;
      out_data_r.wrote        <= s2_wen_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a multiply interlock leaves a bubble in the complete stage
  a_stall_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stall) |=> !s2_valid_r)
    else $error("complete stage not empty after interlock");

  // an interlock clears once its bubble has entered the complete stage
  a_stall_once: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stall) |=> !stall)
    else $error("interlock repeated");

  // register 31 is never written
  a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    commit.en |-> (commit.idx != ioe_pkg::ZeroReg))
    else $error("write to register 31");

  // an unsupported word keeps its empty ALU result through the complete stage
  a_unsupported_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_executed_r && !s2_wen_r && s2_dest_r == 5'd0 && !s2_is_mul_r)
      |-> (s2_result == s2_alu_r))
    else $error("empty result corrupted");

endmodule

[src/ioe_ram.sv]
// ----------------------------------------------------------------------------
// ioe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ioe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/ioe_regfile.sv]
// ----------------------------------------------------------------------------
// ioe_regfile
// Register file: two RAM copies for the two read ports, per-entry valid bits
// standing in for the zero reset, a two-deep history of committed writes and
// the bypass network that resolves both operands in the execute stage.
// ----------------------------------------------------------------------------
module ioe_regfile (
  input  logic                          clk,
  input  logic                          rst_n,
  // read issue, in the stage before execute
  input  logic                          rd_en,
  input  logic [ioe_pkg::RegIdxW-1:0]   rd_addr_a,
  input  logic [ioe_pkg::RegIdxW-1:0]   rd_addr_b,
  // operand indexes of the item now in execute
  input  logic [ioe_pkg::RegIdxW-1:0]   ex_idx_a,
  input  logic [ioe_pkg::RegIdxW-1:0]   ex_idx_b,
  // bypass from the stage after execute
  input  ioe_pkg::wr_t                  s2_fwd,
  // commit port
  input  ioe_pkg::wr_t                  commit,
  output logic [ioe_pkg::DataW-1:0]     opnd_a,
  output logic [ioe_pkg::DataW-1:0]     opnd_b
);

  logic [ioe_pkg::NumRegs-1:0] valid_r;
  ioe_pkg::wr_t                hist1_r;
  ioe_pkg::wr_t                hist2_r;
  logic [ioe_pkg::DataW-1:0]   ram_a;
  logic [ioe_pkg::DataW-1:0]   ram_b;

  // newest write wins, then stored data, unwritten entries read as zero
  function automatic logic [ioe_pkg::DataW-1:0] resolve(
    input logic [ioe_pkg::RegIdxW-1:0] idx,
    input logic [ioe_pkg::DataW-1:0]   ram_data,
    input logic                        ent_valid,
    input ioe_pkg::wr_t                f0,
    input ioe_pkg::wr_t                f1,
    input ioe_pkg::wr_t                f2
  );
    logic [ioe_pkg::DataW-1:0] v;
    if (idx == ioe_pkg::ZeroReg) begin
      v = '0;
    end else if (f0.en && f0.idx == idx) begin
      v = f0.data;
    end else if (f1.en && f1.idx == idx) begin
      v = f1.data;
    end else if (f2.en && f2.idx == idx) begin
      v = f2.data;
    end else if (ent_valid) begin
      v = ram_data;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  // port a copy
  ioe_ram #(
    .WIDTH (ioe_pkg::DataW),
    .DEPTH (ioe_pkg::NumRegs)
  ) u_ram_a (
    .clk   (clk),
    .we    (commit.en),
    .waddr (commit.idx),
    .wdata (commit.data),
    .re    (rd_en),
    .raddr (rd_addr_a),
    .rdata (ram_a)
  );

  // port b copy
  ioe_ram #(
    .WIDTH (ioe_pkg::DataW),
    .DEPTH (ioe_pkg::NumRegs)
  ) u_ram_b (
    .clk   (clk),
    .we    (commit.en),
    .waddr (commit.idx),
    .wdata (commit.data),
    .re    (rd_en),
    .raddr (rd_addr_b),
    .rdata (ram_b)
  );

  // valid bits and committed-write history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      hist1_r.en <= 1'b0;
      hist2_r.en <= 1'b0;
    end else if (commit.en) begin
      valid_r[commit.idx] <= 1'b1;
      hist1_r             <= commit;
      hist2_r             <= hist1_r;
    end
  end

  // operand resolve
  always_comb begin
    opnd_a = resolve(ex_idx_a, ram_a,
                     (ex_idx_a == ioe_pkg::ZeroReg) ? 1'b0 : valid_r[ex_idx_a],
                     s2_fwd, hist1_r, hist2_r);
    opnd_b = resolve(ex_idx_b, ram_b,
                     (ex_idx_b == ioe_pkg::ZeroReg) ? 1'b0 : valid_r[ex_idx_b],
                     s2_fwd, hist1_r, hist2_r);
  end

endmodule

[src/ioe_alu.sv]
// ----------------------------------------------------------------------------
// ioe_alu
// Execute-stage datapath: adds, compares, logic and shifts produce a full
// result; multiply produces three 32x32 partial products, combined later.
// ----------------------------------------------------------------------------
module ioe_alu (
  input  ioe_pkg::alu_op_t            op,
  input  logic [ioe_pkg::DataW-1:0]   a,
  input  logic [ioe_pkg::DataW-1:0]   b,
  input  logic [ioe_pkg::DataW-1:0]   wdata,
  output logic [ioe_pkg::DataW-1:0]   res,
  output logic [63:0]                 pp_ll,
  output logic [31:0]                 pp_lh,
  output logic [31:0]                 pp_hl
);

  logic [63:0] sum;
  logic [63:0] diff;
  logic [5:0]  sh;
  logic        lt_s;
  logic        lt_u;
  logic        eq;

  // shared arithmetic terms
  always_comb begin
    sum  = a + b;
    diff = a - b;
    sh   = b[5:0];
    lt_s = $signed(a) < $signed(b);
    lt_u = a < b;
    eq   = a == b;
  end

  // result select
  always_comb begin
    case (op)
      ioe_pkg::AluAddq:   res = sum;
      ioe_pkg::AluSubq:   res = diff;
      ioe_pkg::AluAddl:   res = {{32{sum[31]}}, sum[31:0]};
      ioe_pkg::AluSubl:   res = {{32{diff[31]}}, diff[31:0]};
      ioe_pkg::AluS4Addq: res = {a[61:0], 2'b00} + b;
      ioe_pkg::AluS8Addq: res = {a[60:0], 3'b000} + b;
      ioe_pkg::AluS4Subq: res = {a[61:0], 2'b00} - b;
      ioe_pkg::AluS8Subq: res = {a[60:0], 3'b000} - b;
      ioe_pkg::AluCmpeq:  res = {63'd0, eq};
      ioe_pkg::AluCmplt:  res = {63'd0, lt_s};
      ioe_pkg::AluCmple:  res = {63'd0, lt_s | eq};
      ioe_pkg::AluCmpult: res = {63'd0, lt_u};
      ioe_pkg::AluCmpule: res = {63'd0, lt_u | eq};
      ioe_pkg::AluAnd:    res = a & b;
      ioe_pkg::AluBis:    res = a | b;
      ioe_pkg::AluXor:    res = a ^ b;
      ioe_pkg::AluBic:    res = a & ~b;
      ioe_pkg::AluOrnot:  res = a | ~b;
      ioe_pkg::AluEqv:    res = a ^ ~b;
      ioe_pkg::AluSll:    res = a << sh;
      ioe_pkg::AluSrl:    res = a >> sh;
      ioe_pkg::AluSra:    res = $unsigned($signed(a) >>> sh);
      ioe_pkg::AluPassA:  res = a;
      ioe_pkg::AluPassW:  res = wdata;
      default:            res = '0;
    endcase
  end

  // multiply partial products, low 64 bits of the product only need the
  // low halves of the cross terms
  always_comb begin
    pp_ll = a[31:0] * b[31:0];
    pp_lh = 32'(a[31:0] * b[63:32]);
    pp_hl = 32'(a[63:32] * b[31:0]);
  end

endmodule

[test/ioe_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ioe_result_checker
// Watches both transfer channels of the integer operate executor. Every input
// transfer is run through a shadow register file and ALU to form the expected
// result. Each output transfer is then compared field by field with the
// oldest expected result.
// ----------------------------------------------------------------------------
module ioe_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ioe_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ioe_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int ReportLimit = 10;

  logic [ioe_pkg::DataW-1:0] shadow_regs [ioe_pkg::NumRegs];
  ioe_pkg::out_item_t        expected_results [$];
  int                        items_taken;
  int                        results_seen;

  assign outstanding = items_taken - results_seen;

  // register 31 reads as zero
  function automatic logic [ioe_pkg::DataW-1:0] reg_value(
    logic [ioe_pkg::RegIdxW-1:0] r
  );
    return (r == ioe_pkg::ZeroReg) ? '0 : shadow_regs[r];
  endfunction

  // opcode and function field to operation, AluZero for unsupported words
  function automatic ioe_pkg::alu_op_t decode_word(logic [31:0] w);
    ioe_pkg::alu_op_t op;
    op = ioe_pkg::AluZero;
    case (w[31:26])
      ioe_pkg::OpcArith: begin
        case (w[11:5])
          ioe_pkg::FnArAddq:   op = ioe_pkg::AluAddq;
          ioe_pkg::FnArSubq:   op = ioe_pkg::AluSubq;
          ioe_pkg::FnArAddl:   op = ioe_pkg::AluAddl;
          ioe_pkg::FnArSubl:   op = ioe_pkg::AluSubl;
          ioe_pkg::FnArS4Addq: op = ioe_pkg::AluS4Addq;
          ioe_pkg::FnArS8Addq: op = ioe_pkg::AluS8Addq;
          ioe_pkg::FnArS4Subq: op = ioe_pkg::AluS4Subq;
          ioe_pkg::FnArS8Subq: op = ioe_pkg::AluS8Subq;
          ioe_pkg::FnArCmpeq:  op = ioe_pkg::AluCmpeq;
          ioe_pkg::FnArCmplt:  op = ioe_pkg::AluCmplt;
          ioe_pkg::FnArCmple:  op = ioe_pkg::AluCmple;
          ioe_pkg::FnArCmpult: op = ioe_pkg::AluCmpult;
          ioe_pkg::FnArCmpule: op = ioe_pkg::AluCmpule;
          default:             op = ioe_pkg::AluZero;
        endcase
      end
      ioe_pkg::OpcLogic: begin
        case (w[11:5])
          ioe_pkg::FnLgAnd:   op = ioe_pkg::AluAnd;
          ioe_pkg::FnLgBis:   op = ioe_pkg::AluBis;
          ioe_pkg::FnLgXor:   op = ioe_pkg::AluXor;
          ioe_pkg::FnLgBic:   op = ioe_pkg::AluBic;
          ioe_pkg::FnLgOrnot: op = ioe_pkg::AluOrnot;
          ioe_pkg::FnLgEqv:   op = ioe_pkg::AluEqv;
          default:            op = ioe_pkg::AluZero;
        endcase
      end
      ioe_pkg::OpcShift: begin
        case (w[11:5])
          ioe_pkg::FnShSll: op = ioe_pkg::AluSll;
          ioe_pkg::FnShSrl: op = ioe_pkg::AluSrl;
          ioe_pkg::FnShSra: op = ioe_pkg::AluSra;
          default:          op = ioe_pkg::AluZero;
        endcase
      end
      ioe_pkg::OpcMul: begin
        if (w[11:5] == ioe_pkg::FnMulq) op = ioe_pkg::AluMulq;
      end
      default: op = ioe_pkg::AluZero;
    endcase
    return op;
  endfunction

  // 64-bit integer operation result
  function automatic logic [ioe_pkg::DataW-1:0] alu_result(
    ioe_pkg::alu_op_t          op,
    logic [ioe_pkg::DataW-1:0] a,
    logic [ioe_pkg::DataW-1:0] b
  );
    logic [ioe_pkg::DataW-1:0] low;
    logic [5:0]                sh;
    sh = b[5:0];
    case (op)
      ioe_pkg::AluAddq:   return a + b;
      ioe_pkg::AluSubq:   return a - b;
      ioe_pkg::AluAddl: begin
        low = a + b;
        return {{32{low[31]}}, low[31:0]};
      end
      ioe_pkg::AluSubl: begin
        low = a - b;
        return {{32{low[31]}}, low[31:0]};
      end
      ioe_pkg::AluS4Addq: return (a << 2) + b;
      ioe_pkg::AluS8Addq: return (a << 3) + b;
      ioe_pkg::AluS4Subq: return (a << 2) - b;
      ioe_pkg::AluS8Subq: return (a << 3) - b;
      ioe_pkg::AluCmpeq:  return {63'd0, a == b};
      ioe_pkg::AluCmplt:  return {63'd0, $signed(a) < $signed(b)};
      ioe_pkg::AluCmple:  return {63'd0, $signed(a) <= $signed(b)};
      ioe_pkg::AluCmpult: return {63'd0, a < b};
      ioe_pkg::AluCmpule: return {63'd0, a <= b};
      ioe_pkg::AluAnd:    return a & b;
      ioe_pkg::AluBis:    return a | b;
      ioe_pkg::AluXor:    return a ^ b;
      ioe_pkg::AluBic:    return a & ~b;
      ioe_pkg::AluOrnot:  return a | ~b;
      ioe_pkg::AluEqv:    return a ^ ~b;
      ioe_pkg::AluSll:    return a << sh;
      ioe_pkg::AluSrl:    return a >> sh;
      ioe_pkg::AluSra:    return $signed(a) >>> sh;
      ioe_pkg::AluMulq:   return a * b;
      default:            return '0;
    endcase
  endfunction

  // result of one item, updating the shadow register file
  function automatic ioe_pkg::out_item_t apply_item(ioe_pkg::in_item_t it);
    ioe_pkg::out_item_t        r;
    ioe_pkg::alu_op_t          op;
    logic [ioe_pkg::DataW-1:0] a;
    logic [ioe_pkg::DataW-1:0] b;
    r = '0;
    case (it.func)
      ioe_pkg::FuncExec: begin
        op = decode_word(it.instr_word);
        if (op != ioe_pkg::AluZero) begin
          a = reg_value(it.instr_word[25:21]);
          b = it.instr_word[12] ? {56'd0, it.instr_word[20:13]}
                                : reg_value(it.instr_word[20:16]);
          r.executed     = 1'b1;
          r.dest_reg     = it.instr_word[4:0];
          r.result_value = alu_result(op, a, b);
          r.wrote        = (r.dest_reg != ioe_pkg::ZeroReg);
          if (r.wrote) shadow_regs[r.dest_reg] = r.result_value;
        end
      end
      ioe_pkg::FuncWrite: begin
        r.dest_reg     = it.reg_index;
        r.result_value = it.write_value;
        r.wrote        = (it.reg_index != ioe_pkg::ZeroReg);
        if (r.wrote) shadow_regs[it.reg_index] = it.write_value;
      end
      ioe_pkg::FuncRead: begin
        r.dest_reg     = it.reg_index;
        r.result_value = reg_value(it.reg_index);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    ioe_pkg::out_item_t want;
    logic               bad;
    if (!rst_n) begin
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      expected_results.delete();
      items_taken  <= 0;
      results_seen <= 0;
      mismatches   = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%0t: result with nothing expected: executed=%0b dest=%0d value=%h wrote=%0b",
                     $realtime, out_data.executed, out_data.dest_reg,
                     out_data.result_value, out_data.wrote);
        end else begin
          want = expected_results.pop_front();
          bad  = 1'b0;
          if (out_data.executed !== want.executed) bad = 1'b1;
          if (out_data.dest_reg !== want.dest_reg) bad = 1'b1;
          if (out_data.result_value !== want.result_value) bad = 1'b1;
          if (out_data.wrote !== want.wrote) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%0t: mismatch expected executed=%0b dest=%0d value=%h wrote=%0b",
                       $realtime, want.executed, want.dest_reg, want.result_value, want.wrote);
              $display("%0t:          actual   executed=%0b dest=%0d value=%h wrote=%0b",
                       $realtime, out_data.executed, out_data.dest_reg,
                       out_data.result_value, out_data.wrote);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_item(in_data));
        items_taken <= items_taken + 1;
      end
    end
  end

endmodule

[test/tb_integer_operate_executor_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_operate_executor_top
// Drives register writes, reads and integer operate words into the executor
// with random gaps and output stalls, including a long output stall and a
// full drain. Checking of every result is done by ioe_result_checker.
// ----------------------------------------------------------------------------
module tb_integer_operate_executor_top;

  localparam int                        ClkHalf     = 10;
  localparam int                        CycleLimit  = 200000;
  localparam int                        HoldCycles  = 120;
  localparam int                        DrainCycles = 12;
  localparam logic [1:0]                FuncUnused  = 2'd3;
  localparam logic [ioe_pkg::DataW-1:0] AllOnes     = '1;
  localparam logic [ioe_pkg::DataW-1:0] MinSigned   = {1'b1, 63'd0};
  localparam logic [ioe_pkg::DataW-1:0] MaxSigned   = {1'b0, {63{1'b1}}};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  ioe_pkg::in_item_t  in_data   = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  ioe_pkg::out_item_t out_data;

  int   send_idle_pct = 35;
  int   recv_idle_pct = 74;
  logic hold_off_req  = 1'b0;
  int   cycle_count   = 0;
  int   mismatches;
  int   outstanding;

  always #(ClkHalf) clk = ~clk;

  integer_operate_executor_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ioe_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_integer_operate_executor_top failed");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_off_req <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // instruction word for one operation
  function automatic logic [31:0] encode_op(ioe_pkg::alu_op_t op, logic [4:0] ra,
                                            logic [4:0] rb, logic [4:0] rc,
                                            logic use_lit, logic [7:0] lit);
    logic [5:0] opc;
    logic [6:0] fn;
    logic [7:0] operand_b;
    case (op)
      ioe_pkg::AluAddq:   begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArAddq;   end
      ioe_pkg::AluSubq:   begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArSubq;   end
      ioe_pkg::AluAddl:   begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArAddl;   end
      ioe_pkg::AluSubl:   begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArSubl;   end
      ioe_pkg::AluS4Addq: begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArS4Addq; end
      ioe_pkg::AluS8Addq: begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArS8Addq; end
      ioe_pkg::AluS4Subq: begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArS4Subq; end
      ioe_pkg::AluS8Subq: begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArS8Subq; end
      ioe_pkg::AluCmpeq:  begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArCmpeq;  end
      ioe_pkg::AluCmplt:  begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArCmplt;  end
      ioe_pkg::AluCmple:  begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArCmple;  end
      ioe_pkg::AluCmpult: begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArCmpult; end
      ioe_pkg::AluCmpule: begin opc = ioe_pkg::OpcArith; fn = ioe_pkg::FnArCmpule; end
      ioe_pkg::AluAnd:    begin opc = ioe_pkg::OpcLogic; fn = ioe_pkg::FnLgAnd;    end
      ioe_pkg::AluBis:    begin opc = ioe_pkg::OpcLogic; fn = ioe_pkg::FnLgBis;    end
      ioe_pkg::AluXor:    begin opc = ioe_pkg::OpcLogic; fn = ioe_pkg::FnLgXor;    end
      ioe_pkg::AluBic:    begin opc = ioe_pkg::OpcLogic; fn = ioe_pkg::FnLgBic;    end
      ioe_pkg::AluOrnot:  begin opc = ioe_pkg::OpcLogic; fn = ioe_pkg::FnLgOrnot;  end
      ioe_pkg::AluEqv:    begin opc = ioe_pkg::OpcLogic; fn = ioe_pkg::FnLgEqv;    end
      ioe_pkg::AluSll:    begin opc = ioe_pkg::OpcShift; fn = ioe_pkg::FnShSll;    end
      ioe_pkg::AluSrl:    begin opc = ioe_pkg::OpcShift; fn = ioe_pkg::FnShSrl;    end
      ioe_pkg::AluSra:    begin opc = ioe_pkg::OpcShift; fn = ioe_pkg::FnShSra;    end
      default:            begin opc = ioe_pkg::OpcMul;   fn = ioe_pkg::FnMulq;     end
    endcase
    // register form leaves three unused bits below rb, filled at random
    operand_b = use_lit ? lit : {rb, 3'($urandom_range(7))};
    return {opc, ra, operand_b, use_lit, fn, rc};
  endfunction

  // mostly a small pool of registers so that results feed later items
  function automatic logic [4:0] pick_reg();
    int p;
    p = $urandom_range(9);
    if (p < 7) return 5'($urandom_range(7));
    if (p == 7) return ioe_pkg::ZeroReg;
    return 5'($urandom);
  endfunction

  function automatic logic [ioe_pkg::DataW-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return AllOnes;
      2:       return MinSigned;
      3:       return MaxSigned;
      4:       return 64'h0000_0000_8000_0000;
      5:       return 64'h0000_0000_FFFF_FFFF;
      6:       return 64'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // exec item with noise in the fields that it does not use
  function automatic ioe_pkg::in_item_t exec_item(logic [31:0] word);
    ioe_pkg::in_item_t it;
    it.func        = ioe_pkg::FuncExec;
    it.instr_word  = word;
    it.reg_index   = 5'($urandom);
    it.write_value = {$urandom, $urandom};
    return it;
  endfunction

  function automatic ioe_pkg::in_item_t access_item(logic [1:0] func, logic [4:0] idx,
                                                    logic [ioe_pkg::DataW-1:0] value);
    ioe_pkg::in_item_t it;
    it.func        = func;
    it.instr_word  = $urandom;
    it.reg_index   = idx;
    it.write_value = value;
    return it;
  endfunction

  function automatic ioe_pkg::in_item_t random_item();
    ioe_pkg::in_item_t it;
    int                pick;
    pick = $urandom_range(99);
    it   = exec_item($urandom);
    if (pick < 55) begin
      it.instr_word = encode_op(ioe_pkg::alu_op_t'(5'($urandom_range(22))), pick_reg(),
                                pick_reg(), pick_reg(), 1'($urandom_range(1)),
                                8'($urandom));
    end else if (pick < 68) begin
      it = access_item(ioe_pkg::FuncWrite, pick_reg(), pick_value());
    end else if (pick < 82) begin
      it = access_item(ioe_pkg::FuncRead, pick_reg(), {$urandom, $urandom});
    end else if (pick < 88) begin
      // known major opcode, random function field
      it.instr_word[31:26] = ioe_pkg::OpcArith + 6'($urandom_range(3));
    end else if (pick >= 95) begin
      it.func = FuncUnused;
    end
    return it;
  endfunction

  // one input transfer, after a random gap
  task automatic drive_item(ioe_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int saved_pct;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, register 31, unused func, unsupported word
    drive_item(access_item(ioe_pkg::FuncWrite, 5'd1, AllOnes));
    drive_item(access_item(ioe_pkg::FuncWrite, 5'd2, MinSigned));
    drive_item(access_item(ioe_pkg::FuncWrite, 5'd3, MaxSigned));
    drive_item(access_item(ioe_pkg::FuncWrite, ioe_pkg::ZeroReg, 64'hDEAD_BEEF_0123_4567));
    drive_item(access_item(ioe_pkg::FuncRead, ioe_pkg::ZeroReg, '0));
    drive_item(access_item(ioe_pkg::FuncRead, 5'd1, '0));
    drive_item(access_item(FuncUnused, 5'd2, AllOnes));
    drive_item(exec_item(32'hFFFF_FFFF));

    // every operation: literal 0xff or register as operand two, and register 31 as destination once
    for (int k = 0; k <= 22; k++) begin
      drive_item(exec_item(encode_op(ioe_pkg::alu_op_t'(5'(k)), 5'(1 + k % 3),
                                     5'(1 + (k + 1) % 3),
                                     (k == 8) ? ioe_pkg::ZeroReg : 5'(4 + k % 8),
                                     (k % 3 == 0), 8'hFF)));
      if (k % 3 == 2) drive_item(access_item(ioe_pkg::FuncRead, 5'(4 + k % 8), '0));
    end

    // phase one: sender idles 35 percent, receiver 74 percent
    for (int n = 0; n < 260; n++) begin
      if (n == 100) begin
        // long output hold-off while items keep coming
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_off_req <= 1'b1;
        for (int m = 0; m < 30; m++) drive_item(random_item());
        send_idle_pct = saved_pct;
        wait_drained();
      end
      drive_item(random_item());
    end

    // phase two: roles swapped
    send_idle_pct = 74;
    recv_idle_pct = 35;
    for (int n = 0; n < 280; n++) drive_item(random_item());

    // phase three: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 280; n++) drive_item(random_item());

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_integer_operate_executor_top passed");
    end else begin
      $display("tb_integer_operate_executor_top failed");
    end
    $finish;
  end

endmodule
